@@ sv/chm_pkg.sv @@
package chm_pkg;

	// table geometry
	localparam int NUM_BUCKETS = 10;
	localparam int CHAIN_DEPTH = 8;
	localparam int BKT_ADDR_W  = $clog2(NUM_BUCKETS);
	localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
	localparam int SLOT_W      = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

	// word field widths
	localparam int CMD_W    = 1;
	localparam int KEY_W    = 31;
	localparam int PRICE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int BUCKET_W = 4;

	// key modulo ten by reciprocal multiply: q = (key * 0xcccccccd) >> 35
	localparam int               RECIP_W     = 32;
	localparam logic [RECIP_W-1:0] RECIP     = 32'hCCCC_CCCD;
	localparam int               RECIP_SHIFT = 35;
	localparam int               PROD_W      = KEY_W + RECIP_W;
	localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

	// commands
	localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// one chain entry and one bucket row
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
	} entry_t;

	typedef entry_t [CHAIN_DEPTH-1:0] row_t;

endpackage

@@ sv/chained_hash_map_insert_remove.sv @@
// channel | handshake          | payload
// --------+--------------------+---------------------
// in      | in_valid, in_stall | cmd, key, price
// out     | out_valid, out_stall | status, bucket
//
// one word passes through accept, hash multiply, bucket row read, compare and write back in turn
// the bucket row memory has one read port and one write port
// a new word is taken once the previous one has reached the output register
// reset clears all chain counts at once; row contents need no clearing pass
// a stalled output holds the write back step until the register drains
module chained_hash_map_insert_remove import chm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    key,
	input  logic [PRICE_W-1:0]  price,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [BUCKET_W-1:0] bucket
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HASH = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0]            state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [PRICE_W-1:0]    price_q;
	logic [PROD_W-1:0]     prod_s1;
	logic [BKT_ADDR_W-1:0] bucket_s2;
	row_t                  row_s3;
	logic [CNT_W-1:0]      cnt_s3;
	logic [CNT_W-1:0]      cnt_q [NUM_BUCKETS];
	row_t                  mem [NUM_BUCKETS];

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [BUCKET_W-1:0]   bucket_q;

	logic                  in_fire;
	logic                  exec_fire;
	logic [QUOT_W-1:0]     quot;
	logic [KEY_W-1:0]      quot_x10;
	logic [KEY_W-1:0]      rem;
	logic [BKT_ADDR_W-1:0] bucket_idx;

	logic [CHAIN_DEPTH-1:0] hit;
	logic                   found;
	logic [SLOT_W-1:0]      pos;
	logic                   full;
	row_t                   new_row;
	logic [CNT_W-1:0]       new_cnt;
	logic                   mem_we;
	logic [STATUS_W-1:0]    new_status;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign exec_fire = (state_q == S_EXEC) && !(out_valid_q && out_stall);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_HASH;
				S_HASH: state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: if (exec_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= cmd;
			key_q   <= key;
			price_q <= price;
		end
	end

	// reciprocal product for the modulo
	always_ff @(posedge clk) begin
		if (state_q == S_HASH) begin
			prod_s1 <= PROD_W'(key_q) * PROD_W'(RECIP);
		end
	end

	// remainder: key minus ten times the quotient
	always_comb begin
		quot       = prod_s1[PROD_W-1:RECIP_SHIFT];
		quot_x10   = (KEY_W'(quot) << 3) + (KEY_W'(quot) << 1);
		rem        = key_q - quot_x10;
		bucket_idx = rem[BKT_ADDR_W-1:0];
	end

	// bucket row read, count fetch
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			bucket_s2 <= bucket_idx;
			row_s3    <= mem[bucket_idx];
			cnt_s3    <= cnt_q[bucket_idx];
		end
		if (mem_we) begin
			mem[bucket_s2] <= new_row;
		end
	end

	// parallel key compare across the chain
	always_comb begin
		for (int i = 0; i < CHAIN_DEPTH; i++) begin
			hit[i] = (CNT_W'(i) < cnt_s3) && (row_s3[i].key == key_q);
		end
		found = 1'b0;
		pos   = '0;
		for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				pos   = SLOT_W'(i);
			end
		end
		full = (cnt_s3 >= CNT_W'(CHAIN_DEPTH));
	end

	// modify the row: update, append or close the gap
	always_comb begin
		new_row    = row_s3;
		new_cnt    = cnt_s3;
		mem_we     = 1'b0;
		new_status = ST_NOT_FOUND;
		case (cmd_q)
			CMD_INSERT: begin
				if (found) begin
					new_row[pos].price = price_q;
					new_status         = ST_UPDATED;
					mem_we             = exec_fire;
				end else if (full) begin
					new_status = ST_FULL;
				end else begin
					new_row[cnt_s3[SLOT_W-1:0]].key   = key_q;
					new_row[cnt_s3[SLOT_W-1:0]].price = price_q;
					new_cnt    = cnt_s3 + CNT_W'(1);
					new_status = ST_INSERTED;
					mem_we     = exec_fire;
				end
			end
			default: begin
				if (cnt_s3 == '0) begin
					new_status = ST_EMPTY;
				end else if (!found) begin
					new_status = ST_NOT_FOUND;
				end else begin
					for (int i = 0; i < CHAIN_DEPTH - 1; i++) begin
						if (SLOT_W'(i) >= pos) begin
							new_row[i] = row_s3[i+1];
						end
					end
					new_cnt    = cnt_s3 - CNT_W'(1);
					new_status = ST_REMOVED;
					mem_we     = exec_fire;
				end
			end
		endcase
	end

	// chain counts, all empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				cnt_q[b] <= '0;
			end
		end else if (mem_we) begin
			cnt_q[bucket_s2] <= new_cnt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q <= new_status;
			bucket_q <= BUCKET_W'(bucket_s2);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bucket    = bucket_q;

	// checks
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while a word is in flight");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_EXEC) && exec_fire)
		else $error("row write outside the write back step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> (cnt_s3 <= CNT_W'(CHAIN_DEPTH)))
		else $error("chain count beyond depth");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> (bucket_s2 < BKT_ADDR_W'(NUM_BUCKETS)))
		else $error("bucket index out of range");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented after write back");

endmodule

@@ verif/tb_chained_hash_map_insert_remove.sv @@
module tb_chained_hash_map_insert_remove import chm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// one input word as queued for the driver
	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
		bit                 wait_drain;
	} request_t;

	// one expected result word
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [BUCKET_W-1:0] bucket;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd = CMD_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic [PRICE_W-1:0]  price = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [BUCKET_W-1:0] bucket;

	request_t requests_to_send[$];
	outcome_t outcomes_due[$];

	// shadow copy of the chained table
	logic [KEY_W-1:0]   chain_key[NUM_BUCKETS][CHAIN_DEPTH];
	logic [PRICE_W-1:0] chain_price[NUM_BUCKETS][CHAIN_DEPTH];
	int                 chain_len[NUM_BUCKETS];

	int status_tally[6];
	int words_in = 0;
	int words_out = 0;
	int errors = 0;
	int hold_left = 0;
	int next_hold_at = 150;
	int holds_done = 0;

	chained_hash_map_insert_remove dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key       (key),
		.price     (price),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.bucket    (bucket)
	);

	// applies one word to the shadow table and returns the status it should give
	function automatic outcome_t table_outcome(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
			logic [PRICE_W-1:0] p);
		outcome_t o;
		int b;
		int n;
		int hit;
		b = int'(k % NUM_BUCKETS);
		n = chain_len[b];
		hit = -1;
		o.bucket = b[BUCKET_W-1:0];
		for (int i = 0; i < n; i++) begin
			if (chain_key[b][i] == k) begin
				hit = i;
				break;
			end
		end
		if (op == CMD_INSERT) begin
			if (hit >= 0) begin
				chain_price[b][hit] = p;
				o.status = ST_UPDATED;
			end else if (n >= CHAIN_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				chain_key[b][n] = k;
				chain_price[b][n] = p;
				chain_len[b] = n + 1;
				o.status = ST_INSERTED;
			end
		end else begin
			if (n == 0) begin
				o.status = ST_EMPTY;
			end else if (hit < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				// close the gap, keeping arrival order
				for (int i = hit; i < n - 1; i++) begin
					chain_key[b][i] = chain_key[b][i + 1];
					chain_price[b][i] = chain_price[b][i + 1];
				end
				chain_len[b] = n - 1;
				o.status = ST_REMOVED;
			end
		end
		status_tally[o.status]++;
		return o;
	endfunction

	task automatic queue_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [PRICE_W-1:0] p,
			bit drain = 1'b0);
		request_t r;
		r.cmd = c;
		r.key = k;
		r.price = p;
		r.wait_drain = drain;
		requests_to_send.push_back(r);
	endtask

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// reset, asserted from time zero and then released
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: predict on acceptance, then offer the next queued word
	always @(posedge clk) begin
		request_t nxt;
		bit sending;
		bit idle;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			sending = in_valid;
			if (in_valid && !in_stall) begin
				outcomes_due.push_back(table_outcome(cmd, key, price));
				words_in++;
				sending = 1'b0;
			end
			if (!sending && requests_to_send.size() > 0) begin
				nxt = requests_to_send[0];
				idle = (words_in < 250 || words_in >= 330) && ($urandom_range(0, 99) < 15);
				if (nxt.wait_drain && outcomes_due.size() != 0)
					idle = 1'b1;
				if (!idle) begin
					void'(requests_to_send.pop_front());
					cmd <= nxt.cmd;
					key <= nxt.key;
					price <= nxt.price;
					sending = 1'b1;
				end
			end
			in_valid <= sending;
		end
	end

	// monitor: check each result word, then choose the stall for the next cycle
	always @(posedge clk) begin
		outcome_t exp_o;
		bit hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_out++;
				if (outcomes_due.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d bucket %0d",
						$time, status, bucket);
					errors++;
				end else begin
					exp_o = outcomes_due.pop_front();
					if (status !== exp_o.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, exp_o.status, status);
						errors++;
					end
					if (bucket !== exp_o.bucket) begin
						$display("%0t: bucket mismatch: expected %0d, got %0d",
							$time, exp_o.bucket, bucket);
						errors++;
					end
				end
			end
			// long hold-off so the block backs up into its input
			if (hold_left == 0 && words_out >= next_hold_at) begin
				hold_left = 80;
				next_hold_at += 270;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold = 1'b1;
			end else begin
				hold = (words_out < 250 || words_out >= 330) && ($urandom_range(0, 99) < 15);
			end
			out_stall <= hold;
		end
	end

	// stimulus and end of run
	initial begin
		int b;
		int r;
		logic [KEY_W-1:0] k;
		logic [CMD_W-1:0] c;
		foreach (chain_len[i]) chain_len[i] = 0;
		foreach (status_tally[i]) status_tally[i] = 0;

		// directed: empty bucket, update, extremes of key and price
		queue_word(CMD_REMOVE, 31'd0, 32'hFFFF_FFFF);
		queue_word(CMD_INSERT, 31'd0, 32'h0000_0000);
		queue_word(CMD_INSERT, 31'd0, 32'hFFFF_FFFF);
		queue_word(CMD_REMOVE, 31'd10, 32'h0);
		queue_word(CMD_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_REMOVE, 31'h7FFF_FFFF, $urandom);
		// fill one chain, then overflow it and update while full
		for (int i = 0; i < CHAIN_DEPTH; i++)
			queue_word(CMD_INSERT, 31'(3 + 10 * i), $urandom);
		queue_word(CMD_INSERT, 31'(3 + 10 * CHAIN_DEPTH), $urandom);
		queue_word(CMD_INSERT, 31'd33, 32'h0001_8000);
		// remove from the middle, head and tail, then check the gap closed
		queue_word(CMD_REMOVE, 31'd23, 32'hFFFF_FFFF);
		queue_word(CMD_REMOVE, 31'd23, 32'h0);
		queue_word(CMD_INSERT, 31'(3 + 10 * (CHAIN_DEPTH + 1)), $urandom);
		queue_word(CMD_REMOVE, 31'd3, 32'h0);
		queue_word(CMD_REMOVE, 31'(3 + 10 * (CHAIN_DEPTH + 1)), 32'h0);
		queue_word(CMD_INSERT, 31'h7FFF_FFFB, 32'h8000_0001);
		queue_word(CMD_REMOVE, 31'd0, 32'h0);

		// random: mostly a small key set per bucket so chains fill and keys recur
		for (int i = 0; i < 600; i++) begin
			r = $urandom_range(0, 99);
			b = $urandom_range(0, NUM_BUCKETS - 1);
			if (r < 70)
				k = 31'(b + 10 * $urandom_range(0, 11));
			else if (r < 85)
				k = 31'h7FFF_FFFF - 31'($urandom_range(0, 29));
			else
				k = 31'($urandom);
			c = ($urandom_range(0, 99) < 60) ? CMD_INSERT : CMD_REMOVE;
			queue_word(c, k, $urandom, (i == 200 || i == 450));
		end

		// wait for the queue to empty and every result to arrive
		@(posedge arst_n);
		while (requests_to_send.size() != 0 || in_valid)
			@(negedge clk);
		while (outcomes_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d words: %0d inserted, %0d updated, %0d removed, %0d empty,",
			words_in, status_tally[ST_INSERTED], status_tally[ST_UPDATED],
			status_tally[ST_REMOVED], status_tally[ST_EMPTY]);
		$display("%0d not found, %0d full; %0d long output hold-offs, two drain pauses",
			status_tally[ST_NOT_FOUND], status_tally[ST_FULL], holds_done);
		if (errors == 0)
			$display("tb_chained_hash_map_insert_remove: done, clean");
		else
			$display("tb_chained_hash_map_insert_remove: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("%0t: timeout with %0d results outstanding", $time, outcomes_due.size());
		$display("tb_chained_hash_map_insert_remove: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
sv/chm_pkg.sv
sv/chained_hash_map_insert_remove.sv
verif/tb_chained_hash_map_insert_remove.sv
